// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk outside of reset.
`define AST_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition that must hold at every rising edge of clk outside of reset.
`define AST_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

`endif

// File: rtl/core/bmg_pkg.sv
// Shared constants, types and fixed-point helpers of the Gaussian pair generator.
`default_nettype none
package bmg_pkg;

   localparam int UNIFORM_BITS  = 32;
   localparam int ANGLE_BITS    = 16;
   localparam int OUT_FRAC_BITS = 12;
   localparam int OUT_BITS      = 16;

   localparam int M_BITS = UNIFORM_BITS + 1;
   localparam int E_BITS = $clog2(M_BITS);

   localparam logic [63:0] LN2_Q58     = 64'h02C5C85FDF473DE7;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;

   localparam int DIV_STEPS   = 62;
   localparam int LOG_TERMS   = 22;
   localparam int TRIG_TERMS  = 14;
   localparam int SQRT_STEPS  = 32;
   localparam int TERM_STAGES = 5;

   localparam int LOG_LAT    = 1 + DIV_STEPS + 2 + TERM_STAGES * LOG_TERMS + 1;
   localparam int RAD_LAT    = LOG_LAT + SQRT_STEPS;
   localparam int TRIG_LAT   = 4 + TERM_STAGES * TRIG_TERMS;
   localparam int ALIGN_LAT  = RAD_LAT - TRIG_LAT;
   localparam int SCALE_LAT  = 3;
   localparam int PIPE_LAT   = RAD_LAT + SCALE_LAT;

   // Four 32x32 partial products of a 64x64 product.
   typedef struct packed {
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } pp_type;

   function automatic pp_type mul_pp(logic [63:0] a, logic [63:0] b);
      pp_type r;
      r.p00 = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
      r.p01 = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
      r.p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
      r.p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
      return r;
   endfunction

   // Floor of the full product over 2^62, kept to 64 bits.
   function automatic logic [63:0] mul_join(pp_type pp);
      logic [127:0] full;
      full = {pp.p11, 64'd0} + {32'd0, pp.p01, 32'd0} + {32'd0, pp.p10, 32'd0}
           + {64'd0, pp.p00};
      return full[125:62];
   endfunction

   // Upper 64 bits of the full product.
   function automatic logic [63:0] mul_high(pp_type pp);
      logic [127:0] full;
      full = {pp.p11, 64'd0} + {32'd0, pp.p01, 32'd0} + {32'd0, pp.p10, 32'd0}
           + {64'd0, pp.p00};
      return full[127:64];
   endfunction

   // A reciprocal estimate of x/k is at most one short; one compare settles it.
   function automatic logic [63:0] quot_fix(logic [63:0] x, logic [63:0] q0,
                                            logic [9:0] k);
      logic [63:0] r;
      r = x - q0 * 64'(k);
      return (r >= 64'(k)) ? q0 + 64'd1 : q0;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/bmg_log.sv
// Pipelined -ln(u1) in Q58: long division for z, then an odd atanh series.
`default_nettype none
module bmg_log import bmg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [UNIFORM_BITS-1:0] in_value,
   output logic                    out_valid,
   output logic [63:0]             out_x58
);

   localparam int NW = M_BITS + 2;

   // Division stages, index 0 holds the operands.
   logic              dv_valid_ff [0:DIV_STEPS];
   logic [NW-1:0]     dv_num_ff   [0:DIV_STEPS];
   logic [NW-1:0]     dv_den_ff   [0:DIV_STEPS];
   logic [61:0]       dv_q_ff     [0:DIV_STEPS];
   logic [E_BITS-1:0] dv_e_ff     [0:DIV_STEPS];

   logic [M_BITS-1:0] m_in;
   logic [M_BITS-1:0] p_in;
   logic [E_BITS-1:0] e_in;

   always_comb begin
      m_in = M_BITS'(in_value) + M_BITS'(1);
      e_in = '0;
      for (int i = 0; i < M_BITS; i++) begin
         if (m_in[i]) begin
            e_in = E_BITS'(i);
         end
      end
      p_in = M_BITS'(1) << e_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= in_valid;
      end
      dv_num_ff[0] <= NW'(m_in - p_in);
      dv_den_ff[0] <= NW'(m_in) + NW'(p_in);
      dv_q_ff[0]   <= '0;
      dv_e_ff[0]   <= e_in;
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
      logic [NW-1:0] sh;
      logic          ge;
      assign sh = dv_num_ff[j-1] << 1;
      assign ge = sh >= dv_den_ff[j-1];
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
         dv_num_ff[j] <= ge ? sh - dv_den_ff[j-1] : sh;
         dv_den_ff[j] <= dv_den_ff[j-1];
         dv_q_ff[j]   <= {dv_q_ff[j-1][60:0], ge};
         dv_e_ff[j]   <= dv_e_ff[j-1];
      end
   end

   // z squared over two stages.
   logic              sq_valid_ff;
   pp_type            sq_pp_ff;
   logic [63:0]       sq_z_ff;
   logic [E_BITS-1:0] sq_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= dv_valid_ff[DIV_STEPS];
      end
      sq_pp_ff <= mul_pp({2'b00, dv_q_ff[DIV_STEPS]}, {2'b00, dv_q_ff[DIV_STEPS]});
      sq_z_ff  <= {2'b00, dv_q_ff[DIV_STEPS]};
      sq_e_ff  <= dv_e_ff[DIV_STEPS];
   end

   // Series state, index 0 holds the first term.
   logic              tm_valid_ff [0:LOG_TERMS];
   logic [63:0]       tm_term_ff  [0:LOG_TERMS];
   logic [63:0]       tm_sum_ff   [0:LOG_TERMS];
   logic [63:0]       tm_z2_ff    [0:LOG_TERMS];
   logic [E_BITS-1:0] tm_e_ff     [0:LOG_TERMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         tm_valid_ff[0] <= 1'b0;
      end else begin
         tm_valid_ff[0] <= sq_valid_ff;
      end
      tm_term_ff[0] <= sq_z_ff;
      tm_sum_ff[0]  <= sq_z_ff;
      tm_z2_ff[0]   <= mul_join(sq_pp_ff);
      tm_e_ff[0]    <= sq_e_ff;
   end

   for (genvar k = 0; k < LOG_TERMS; k++) begin : g_term
      localparam logic [9:0]  Kdiv = 10'(2 * k + 3);
      localparam logic [63:0] Krcp = 64'((65'd1 << 64) / 65'(2 * k + 3));
      logic              a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
      pp_type            a_pp_ff, c_pp_ff;
      logic [63:0]       a_sum_ff, a_z2_ff, b_sum_ff, b_z2_ff, b_raw_ff;
      logic [63:0]       c_sum_ff, c_z2_ff, c_raw_ff;
      logic [63:0]       d_sum_ff, d_z2_ff, d_raw_ff, d_q0_ff;
      logic [E_BITS-1:0] a_e_ff, b_e_ff, c_e_ff, d_e_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff       <= 1'b0;
            b_valid_ff       <= 1'b0;
            c_valid_ff       <= 1'b0;
            d_valid_ff       <= 1'b0;
            tm_valid_ff[k+1] <= 1'b0;
         end else begin
            a_valid_ff       <= tm_valid_ff[k];
            b_valid_ff       <= a_valid_ff;
            c_valid_ff       <= b_valid_ff;
            d_valid_ff       <= c_valid_ff;
            tm_valid_ff[k+1] <= d_valid_ff;
         end
         a_pp_ff  <= mul_pp(tm_term_ff[k], tm_z2_ff[k]);
         a_sum_ff <= tm_sum_ff[k];
         a_z2_ff  <= tm_z2_ff[k];
         a_e_ff   <= tm_e_ff[k];
         b_raw_ff <= mul_join(a_pp_ff);
         b_sum_ff <= a_sum_ff;
         b_z2_ff  <= a_z2_ff;
         b_e_ff   <= a_e_ff;
         c_pp_ff  <= mul_pp(b_raw_ff, Krcp);
         c_raw_ff <= b_raw_ff;
         c_sum_ff <= b_sum_ff;
         c_z2_ff  <= b_z2_ff;
         c_e_ff   <= b_e_ff;
         d_q0_ff  <= mul_high(c_pp_ff);
         d_raw_ff <= c_raw_ff;
         d_sum_ff <= c_sum_ff;
         d_z2_ff  <= c_z2_ff;
         d_e_ff   <= c_e_ff;
         tm_term_ff[k+1] <= d_raw_ff;
         tm_sum_ff[k+1]  <= d_sum_ff + quot_fix(d_raw_ff, d_q0_ff, Kdiv);
         tm_z2_ff[k+1]   <= d_z2_ff;
         tm_e_ff[k+1]    <= d_e_ff;
      end
   end

   logic [63:0] lnf;
   logic [63:0] pw;
   logic [6:0]  ue;

   always_comb begin
      lnf = ((tm_sum_ff[LOG_TERMS] << 1) + 64'd8) >> 4;
      ue  = 7'(UNIFORM_BITS) - 7'(tm_e_ff[LOG_TERMS]);
      pw  = {57'd0, ue} * LN2_Q58;
   end

   logic        out_valid_ff;
   logic [63:0] out_x58_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= tm_valid_ff[LOG_TERMS];
      end
      if ((32'(tm_e_ff[LOG_TERMS]) > 32'(UNIFORM_BITS)) || (lnf > pw)) begin
         out_x58_ff <= '0;
      end else begin
         out_x58_ff <= pw - lnf;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x58   = out_x58_ff;

endmodule
`default_nettype wire

// File: rtl/core/bmg_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module bmg_sqrt import bmg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_value,
   output logic        out_valid,
   output logic [31:0] out_root
);

   logic        sq_valid_ff [1:SQRT_STEPS];
   logic [63:0] sq_rem_ff   [1:SQRT_STEPS];
   logic [63:0] sq_res_ff   [1:SQRT_STEPS];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
      logic        st_valid;
      logic [63:0] st_rem, st_res, trial;
      if (i == 0) begin : g_first
         assign st_valid = in_valid;
         assign st_rem   = in_value;
         assign st_res   = '0;
      end else begin : g_next
         assign st_valid = sq_valid_ff[i];
         assign st_rem   = sq_rem_ff[i];
         assign st_res   = sq_res_ff[i];
      end
      assign trial = st_res + Bit;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[i+1] <= 1'b0;
         end else begin
            sq_valid_ff[i+1] <= st_valid;
         end
         if (st_rem >= trial) begin
            sq_rem_ff[i+1] <= st_rem - trial;
            sq_res_ff[i+1] <= (st_res >> 1) + Bit;
         end else begin
            sq_rem_ff[i+1] <= st_rem;
            sq_res_ff[i+1] <= st_res >> 1;
         end
      end
   end

   assign out_valid = sq_valid_ff[SQRT_STEPS];
   assign out_root  = sq_res_ff[SQRT_STEPS][31:0];

endmodule
`default_nettype wire

// File: rtl/core/bmg_trig.sv
// Pipelined sine and cosine of a quarter-turn angle by Taylor series in Q62.
`default_nettype none
module bmg_trig import bmg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ANGLE_BITS-1:0] in_angle,
   output logic                  out_valid,
   output logic [1:0]            out_quad,
   output logic signed [63:0]    out_sin,
   output logic signed [63:0]    out_cos
);

   localparam int T_BITS = ANGLE_BITS - 2;

   logic        th_valid_ff, th_valid2_ff, th2_valid_ff;
   pp_type      th_pp_ff, th2_pp_ff;
   logic [63:0] th_ff, th2_th_ff;
   logic [1:0]  th_quad_ff, th_quad2_ff, th2_quad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         th_valid_ff  <= 1'b0;
         th_valid2_ff <= 1'b0;
         th2_valid_ff <= 1'b0;
      end else begin
         th_valid_ff  <= in_valid;
         th_valid2_ff <= th_valid_ff;
         th2_valid_ff <= th_valid2_ff;
      end
      th_pp_ff    <= mul_pp(64'(in_angle[T_BITS-1:0]) << (62 - T_BITS), HALF_PI_Q62);
      th_quad_ff  <= in_angle[ANGLE_BITS-1 -: 2];
      th_ff       <= mul_join(th_pp_ff);
      th_quad2_ff <= th_quad_ff;
      th2_pp_ff   <= mul_pp(th_ff, th_ff);
      th2_th_ff   <= th_ff;
      th2_quad_ff <= th_quad2_ff;
   end

   logic               ti_valid_ff [0:TRIG_TERMS];
   logic [63:0]        ti_tc_ff    [0:TRIG_TERMS];
   logic [63:0]        ti_ts_ff    [0:TRIG_TERMS];
   logic signed [63:0] ti_cs_ff    [0:TRIG_TERMS];
   logic signed [63:0] ti_ss_ff    [0:TRIG_TERMS];
   logic [63:0]        ti_th2_ff   [0:TRIG_TERMS];
   logic [1:0]         ti_quad_ff  [0:TRIG_TERMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ti_valid_ff[0] <= 1'b0;
      end else begin
         ti_valid_ff[0] <= th2_valid_ff;
      end
      ti_tc_ff[0]   <= ONE_Q62;
      ti_ts_ff[0]   <= th2_th_ff;
      ti_cs_ff[0]   <= $signed(ONE_Q62);
      ti_ss_ff[0]   <= $signed(th2_th_ff);
      ti_th2_ff[0]  <= mul_join(th2_pp_ff);
      ti_quad_ff[0] <= th2_quad_ff;
   end

   for (genvar i = 0; i < TRIG_TERMS; i++) begin : g_term
      localparam logic [9:0]  Kcos = 10'((2 * i + 2) * (2 * i + 1));
      localparam logic [9:0]  Ksin = 10'((2 * i + 3) * (2 * i + 2));
      localparam logic [63:0] Rcos = 64'((65'd1 << 64) / 65'((2 * i + 2) * (2 * i + 1)));
      localparam logic [63:0] Rsin = 64'((65'd1 << 64) / 65'((2 * i + 3) * (2 * i + 2)));
      localparam bit Subtract = (i % 2) == 0;
      logic               a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
      pp_type             a_pc_ff, a_ps_ff, c_pc_ff, c_ps_ff;
      logic [63:0]        a_th2_ff, b_th2_ff, c_th2_ff, d_th2_ff;
      logic [63:0]        b_rc_ff, b_rs_ff, c_rc_ff, c_rs_ff, d_rc_ff, d_rs_ff;
      logic [63:0]        d_qc_ff, d_qs_ff, tc, ts;
      logic signed [63:0] a_cs_ff, a_ss_ff, b_cs_ff, b_ss_ff;
      logic signed [63:0] c_cs_ff, c_ss_ff, d_cs_ff, d_ss_ff;
      logic [1:0]         a_quad_ff, b_quad_ff, c_quad_ff, d_quad_ff;

      assign tc = quot_fix(d_rc_ff, d_qc_ff, Kcos);
      assign ts = quot_fix(d_rs_ff, d_qs_ff, Ksin);

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff       <= 1'b0;
            b_valid_ff       <= 1'b0;
            c_valid_ff       <= 1'b0;
            d_valid_ff       <= 1'b0;
            ti_valid_ff[i+1] <= 1'b0;
         end else begin
            a_valid_ff       <= ti_valid_ff[i];
            b_valid_ff       <= a_valid_ff;
            c_valid_ff       <= b_valid_ff;
            d_valid_ff       <= c_valid_ff;
            ti_valid_ff[i+1] <= d_valid_ff;
         end
         a_pc_ff   <= mul_pp(ti_tc_ff[i], ti_th2_ff[i]);
         a_ps_ff   <= mul_pp(ti_ts_ff[i], ti_th2_ff[i]);
         a_cs_ff   <= ti_cs_ff[i];
         a_ss_ff   <= ti_ss_ff[i];
         a_th2_ff  <= ti_th2_ff[i];
         a_quad_ff <= ti_quad_ff[i];
         b_rc_ff   <= mul_join(a_pc_ff);
         b_rs_ff   <= mul_join(a_ps_ff);
         b_cs_ff   <= a_cs_ff;
         b_ss_ff   <= a_ss_ff;
         b_th2_ff  <= a_th2_ff;
         b_quad_ff <= a_quad_ff;
         c_pc_ff   <= mul_pp(b_rc_ff, Rcos);
         c_ps_ff   <= mul_pp(b_rs_ff, Rsin);
         c_rc_ff   <= b_rc_ff;
         c_rs_ff   <= b_rs_ff;
         c_cs_ff   <= b_cs_ff;
         c_ss_ff   <= b_ss_ff;
         c_th2_ff  <= b_th2_ff;
         c_quad_ff <= b_quad_ff;
         d_qc_ff   <= mul_high(c_pc_ff);
         d_qs_ff   <= mul_high(c_ps_ff);
         d_rc_ff   <= c_rc_ff;
         d_rs_ff   <= c_rs_ff;
         d_cs_ff   <= c_cs_ff;
         d_ss_ff   <= c_ss_ff;
         d_th2_ff  <= c_th2_ff;
         d_quad_ff <= c_quad_ff;
         ti_tc_ff[i+1]   <= tc;
         ti_ts_ff[i+1]   <= ts;
         ti_th2_ff[i+1]  <= d_th2_ff;
         ti_quad_ff[i+1] <= d_quad_ff;
         if (Subtract) begin
            ti_cs_ff[i+1] <= d_cs_ff - $signed(tc);
            ti_ss_ff[i+1] <= d_ss_ff - $signed(ts);
         end else begin
            ti_cs_ff[i+1] <= d_cs_ff + $signed(tc);
            ti_ss_ff[i+1] <= d_ss_ff + $signed(ts);
         end
      end
   end

   assign out_valid = ti_valid_ff[TRIG_TERMS];
   assign out_quad  = ti_quad_ff[TRIG_TERMS];
   assign out_sin   = ti_ss_ff[TRIG_TERMS];
   assign out_cos   = ti_cs_ff[TRIG_TERMS];

endmodule
`default_nettype wire

// File: rtl/core/bmg_scale.sv
// Quadrant fold, radius multiply, rounding and saturation of both samples.
`default_nettype none
module bmg_scale import bmg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [31:0]                in_root,
   input  logic [1:0]                 in_quad,
   input  logic signed [63:0]         in_sin,
   input  logic signed [63:0]         in_cos,
   output logic                       out_valid,
   output logic signed [OUT_BITS-1:0] out_cos,
   output logic signed [OUT_BITS-1:0] out_sin
);

   localparam int SH     = 60 - OUT_FRAC_BITS;
   localparam int R_BITS = 66 - SH;
   localparam logic [R_BITS-1:0] POS_MAX = R_BITS'((1 << (OUT_BITS - 1)) - 1);
   localparam logic [R_BITS-1:0] NEG_MAX = R_BITS'(1 << (OUT_BITS - 1));
   localparam logic [65:0] HALF = 66'd1 << (SH - 1);

   function automatic logic [32:0] to_c32(logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] rnd;
      mag = v[63] ? 64'd0 - 64'(v) : 64'(v);
      rnd = mag + (64'd1 << 29);
      return rnd[62:30];
   endfunction

   function automatic logic [OUT_BITS-1:0] round_sat(logic [64:0] prod, logic neg);
      logic [65:0]       sum;
      logic [R_BITS-1:0] res;
      sum = {1'b0, prod} + HALF;
      res = sum[65:SH];
      if (neg) begin
         if (res > NEG_MAX) begin
            res = NEG_MAX;
         end
         return OUT_BITS'(R_BITS'(0) - res);
      end else begin
         if (res > POS_MAX) begin
            res = POS_MAX;
         end
         return OUT_BITS'(res);
      end
   endfunction

   logic signed [63:0] co, si;

   always_comb begin
      unique case (in_quad)
         2'd0: begin co = in_cos;  si = in_sin;  end
         2'd1: begin co = -in_sin; si = in_cos;  end
         2'd2: begin co = -in_cos; si = -in_sin; end
         2'd3: begin co = in_sin;  si = -in_cos; end
         default: begin co = in_cos; si = in_sin; end
      endcase
   end

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [31:0] s1_root_ff;
   logic [32:0] s1_cc_ff, s1_sc_ff;
   logic        s1_cn_ff, s1_sn_ff, s2_cn_ff, s2_sn_ff;
   logic [64:0] s2_cp_ff, s2_sp_ff;
   logic [OUT_BITS-1:0] s3_cos_ff, s3_sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_root_ff <= in_root;
      s1_cc_ff   <= to_c32(co);
      s1_sc_ff   <= to_c32(si);
      s1_cn_ff   <= co[63];
      s1_sn_ff   <= si[63];
      s2_cp_ff   <= {33'd0, s1_root_ff} * {32'd0, s1_cc_ff};
      s2_sp_ff   <= {33'd0, s1_root_ff} * {32'd0, s1_sc_ff};
      s2_cn_ff   <= s1_cn_ff;
      s2_sn_ff   <= s1_sn_ff;
      s3_cos_ff  <= round_sat(s2_cp_ff, s2_cn_ff);
      s3_sin_ff  <= round_sat(s2_sp_ff, s2_sn_ff);
   end

   assign out_valid = s3_valid_ff;
   assign out_cos   = $signed(s3_cos_ff);
   assign out_sin   = $signed(s3_sin_ff);

endmodule
`default_nettype wire

// File: rtl/core/box_muller_gaussian_pair.sv
// Top level of the Box-Muller Gaussian pair generator.
// The block takes one item per clock cycle and never raises busy. Each item's
// sample pair appears on the rsp_ ports with rsp_valid at the end of the
// pipeline; the receiver cannot stall, so a result is shown for one cycle
// only. The depth of the pipeline is set by the radius path:
// a 62-stage long division and a 22-term log series (five stages per term,
// the divide by each term's constant being a reciprocal multiply and a
// one-step fix), followed by a 32-stage square root and three output stages.
// The angle path is shorter and is delayed to line up with the radius.
`default_nettype none
module box_muller_gaussian_pair import bmg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [UNIFORM_BITS-1:0]    req_radius_uniform,
   input  logic [ANGLE_BITS-1:0]      req_angle_uniform,
   output logic                       rsp_valid,
   output logic signed [OUT_BITS-1:0] rsp_normal_cos,
   output logic signed [OUT_BITS-1:0] rsp_normal_sin
);

   logic        log_valid;
   logic [63:0] log_x58;
   logic        rt_valid;
   logic [31:0] rt_root;

   assign busy = 1'b0;

   bmg_log u_log (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_value  (req_radius_uniform),
      .out_valid (log_valid),
      .out_x58   (log_x58)
   );

   bmg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (log_valid),
      .in_value  (log_x58 >> 1),
      .out_valid (rt_valid),
      .out_root  (rt_root)
   );

   // Delay line that lines the angle up with the radius.
   logic                  al_valid_ff [0:ALIGN_LAT-1];
   logic [ANGLE_BITS-1:0] al_angle_ff [0:ALIGN_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         al_valid_ff[0] <= 1'b0;
      end else begin
         al_valid_ff[0] <= start;
      end
      al_angle_ff[0] <= req_angle_uniform;
   end

   for (genvar i = 1; i < ALIGN_LAT; i++) begin : g_align
      always_ff @(posedge clock) begin
         if (reset) begin
            al_valid_ff[i] <= 1'b0;
         end else begin
            al_valid_ff[i] <= al_valid_ff[i-1];
         end
         al_angle_ff[i] <= al_angle_ff[i-1];
      end
   end

   logic               tr_valid;
   logic [1:0]         tr_quad;
   logic signed [63:0] tr_sin, tr_cos;

   bmg_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (al_valid_ff[ALIGN_LAT-1]),
      .in_angle  (al_angle_ff[ALIGN_LAT-1]),
      .out_valid (tr_valid),
      .out_quad  (tr_quad),
      .out_sin   (tr_sin),
      .out_cos   (tr_cos)
   );

   bmg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid & tr_valid),
      .in_root   (rt_root),
      .in_quad   (tr_quad),
      .in_sin    (tr_sin),
      .in_cos    (tr_cos),
      .out_valid (rsp_valid),
      .out_cos   (rsp_normal_cos),
      .out_sin   (rsp_normal_sin)
   );

endmodule
`default_nettype wire

// File: rtl/core/bmg_checker.sv
// Port-level checker of the Gaussian pair generator and its bind.
`default_nettype none
`include "assert_macros.svh"
module bmg_checker import bmg_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [UNIFORM_BITS-1:0]    req_radius_uniform,
   input logic [ANGLE_BITS-1:0]      req_angle_uniform,
   input logic                       rsp_valid,
   input logic signed [OUT_BITS-1:0] rsp_normal_cos,
   input logic signed [OUT_BITS-1:0] rsp_normal_sin
);

   // The largest radius code means a zero radius; a zero angle means a zero sine.
   logic top_code, zero_angle, zero_out;
   assign top_code   = &req_radius_uniform;
   assign zero_angle = (req_angle_uniform == '0);
   assign zero_out   = (rsp_normal_cos == '0) && (rsp_normal_sin == '0);

   `AST_IMPLIES(a_item_returns, clock, reset, start && !busy, ##PIPE_LAT rsp_valid)
   `AST_IMPLIES(a_no_spurious, clock, reset, rsp_valid, $past(start, PIPE_LAT))
   `AST_IMPLIES(a_zero_radius, clock, reset, rsp_valid && $past(top_code, PIPE_LAT), zero_out)
   `AST_IMPLIES(a_zero_sine, clock, reset, rsp_valid && $past(zero_angle, PIPE_LAT), rsp_normal_sin == '0)
   `AST_ALWAYS(a_never_busy, clock, reset, !busy)

endmodule

bind box_muller_gaussian_pair bmg_checker u_bmg_checker (.*);
`default_nettype wire
